// File: rtl/lafi_pkg.sv
// Types and constants shared by the launch arm and fire interlock.
package lafi_pkg;

  localparam int NUM_LANES = 4;

  localparam logic [1:0] KIND_PACKET  = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RX_FAIL = 2'd2;

  localparam logic [1:0] BATT_GOOD     = 2'd0;
  localparam logic [1:0] BATT_LOW      = 2'd1;
  localparam logic [1:0] BATT_REVERSED = 2'd2;

  localparam logic [1:0] MODE_CHANNEL   = 2'd0;
  localparam logic [1:0] MODE_LOW_BATT  = 2'd1;
  localparam logic [1:0] MODE_REVERSED  = 2'd2;
  localparam logic [1:0] MODE_LINK_FAIL = 2'd3;

  localparam logic [2:0] LED_UNCHANGED = 3'd0;
  localparam logic [2:0] LED_ARMED     = 3'd1;
  localparam logic [2:0] LED_LATCHED   = 3'd2;
  localparam logic [2:0] LED_CLOSED    = 3'd3;
  localparam logic [2:0] LED_OPEN      = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic       armed;
    logic       fired;
    logic       mark_keep;
    logic [2:0] led;
  } lafi_lane_res_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] fired_marks;
    logic                 fire_enabled;
    logic                 fire_held;
  } lafi_state_t;

  typedef struct packed {
    logic                       response_sent;
    logic [NUM_LANES-1:0]       armed_report;
    logic [NUM_LANES-1:0]       fired_report;
    logic                       fire_command;
    logic [1:0]                 whole_led_mode;
    logic [NUM_LANES-1:0][2:0]  led_code;
  } lafi_word_t;

endpackage

// File: rtl/lafi_if.sv
// Valid/ready channel interfaces for input items and result words.
interface lafi_in_if;
  import lafi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [NUM_LANES-1:0] arm_buttons;
  logic                 fire_button;
  logic [NUM_LANES-1:0] continuity_mask;
  logic [1:0]           battery_status;

  modport source (output valid, kind, arm_buttons, fire_button, continuity_mask,
                  battery_status, input ready);
  modport sink (input valid, kind, arm_buttons, fire_button, continuity_mask,
                battery_status, output ready);
endinterface

interface lafi_out_if;
  import lafi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 response_sent;
  logic [NUM_LANES-1:0] armed_report;
  logic [NUM_LANES-1:0] fired_report;
  logic                 fire_command;
  logic [1:0]           whole_led_mode;
  logic [2:0]           led_code_0;
  logic [2:0]           led_code_1;
  logic [2:0]           led_code_2;
  logic [2:0]           led_code_3;

  modport source (output valid, response_sent, armed_report, fired_report, fire_command,
                  whole_led_mode, led_code_0, led_code_1, led_code_2, led_code_3,
                  input ready);
  modport sink (input valid, response_sent, armed_report, fired_report, fire_command,
                whole_led_mode, led_code_0, led_code_1, led_code_2, led_code_3,
                output ready);
endinterface

// File: rtl/lafi_lane.sv
// Per-charge lane: arm and fired status, fired-mark hold and LED code of one charge.
module lafi_lane (
  input  logic                     arm_button,
  input  logic                     continuity,
  input  logic                     fired_mark,
  input  logic                     fire_button,
  input  logic [1:0]               battery_status,
  output lafi_pkg::lafi_lane_res_t res
);
  import lafi_pkg::*;

  logic engaged;

  assign engaged = arm_button & continuity;

  always_comb begin
    res.armed     = engaged & ~fired_mark;
    res.fired     = engaged & fired_mark;
    res.mark_keep = fired_mark & (engaged | fire_button);
    if (battery_status != BATT_GOOD) begin
      res.led = LED_UNCHANGED;
    end else if (res.armed) begin
      res.led = LED_ARMED;
    end else if (res.fired) begin
      res.led = LED_LATCHED;
    end else if (continuity) begin
      res.led = LED_CLOSED;
    end else begin
      res.led = LED_OPEN;
    end
  end

endmodule

// File: rtl/lafi_merge.sv
// Merge stage: combines the lane results into the reply word and the next interlock state.
module lafi_merge (
  input  lafi_pkg::lafi_lane_res_t [lafi_pkg::NUM_LANES-1:0] lane_res,
  input  logic                                               fire_button,
  input  logic [1:0]                                         battery_status,
  input  lafi_pkg::lafi_state_t                              state_cur,
  output lafi_pkg::lafi_state_t                              state_nxt,
  output lafi_pkg::lafi_word_t                               word
);
  import lafi_pkg::*;

  logic [NUM_LANES-1:0] armed;
  logic [NUM_LANES-1:0] fired;
  logic [NUM_LANES-1:0] keep;
  logic                 cmd;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      armed[i]         = lane_res[i].armed;
      fired[i]         = lane_res[i].fired;
      keep[i]          = lane_res[i].mark_keep;
      word.led_code[i] = lane_res[i].led;
    end
    cmd = fire_button & (|armed) & state_cur.fire_enabled & state_cur.fire_held;

    state_nxt.fired_marks = keep | (cmd ? armed : '0);
    state_nxt.fire_held   = fire_button;
    if (fire_button) begin
      state_nxt.fire_enabled = state_cur.fire_enabled & ~cmd;
    end else begin
      state_nxt.fire_enabled = state_cur.fire_enabled | ~state_cur.fire_held;
    end

    word.response_sent = 1'b1;
    word.armed_report  = armed;
    word.fired_report  = fired;
    word.fire_command  = cmd;
    case (battery_status)
      BATT_LOW:      word.whole_led_mode = MODE_LOW_BATT;
      BATT_REVERSED: word.whole_led_mode = MODE_REVERSED;
      default:       word.whole_led_mode = MODE_CHANNEL;
    endcase
  end

endmodule

// File: rtl/launch_arm_fire_interlock_top.sv
// Top level of the launch arm and fire interlock.
// The block takes one input word every clock cycle while input ready is high; each word is
// decided when accepted by up to four charge lanes and a merge stage, and its reply goes to
// the output register, or to a one-word skid register behind it while a reply waits to be
// taken; input ready drops only when both hold a word. Ticks update the link counter and
// give no reply; a receive failure at or above the timeout clears it and gives a link
// failure reply. The link timeout register may be written at any time the block is idle.
module launch_arm_fire_interlock_top #(
  parameter int NUM_CHARGES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  lafi_in_if.sink           in_ch,
  lafi_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import lafi_pkg::*;

  localparam int ACTIVE_LANES = (NUM_CHARGES < NUM_LANES) ? NUM_CHARGES : NUM_LANES;

  logic [15:0]  timeout_r;
  logic [15:0]  ticks_r;
  logic [15:0]  ticks_nxt;
  lafi_state_t  state_r;
  lafi_state_t  state_nxt;
  lafi_state_t  merge_state;
  lafi_word_t   merge_word;
  lafi_word_t   res_word;
  lafi_word_t   out_word_r;
  lafi_word_t   skid_word_r;
  logic         out_valid_r;
  logic         skid_valid_r;
  logic         in_accept;
  logic         res_valid;
  logic         out_take;
  lafi_lane_res_t [NUM_LANES-1:0] lane_res;

  genvar g;
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      if (g < ACTIVE_LANES) begin : g_on
        lafi_lane u_lane (
          .arm_button     (in_ch.arm_buttons[g]),
          .continuity     (in_ch.continuity_mask[g]),
          .fired_mark     (state_r.fired_marks[g]),
          .fire_button    (in_ch.fire_button),
          .battery_status (in_ch.battery_status),
          .res            (lane_res[g])
        );
      end else begin : g_off
        assign lane_res[g] = '0;
      end
    end
  endgenerate

  lafi_merge u_merge (
    .lane_res       (lane_res),
    .fire_button    (in_ch.fire_button),
    .battery_status (in_ch.battery_status),
    .state_cur      (state_r),
    .state_nxt      (merge_state),
    .word           (merge_word)
  );

  assign in_ch.ready = ~skid_valid_r;
  assign in_accept   = in_ch.valid & ~skid_valid_r;
  assign out_take    = out_valid_r & out_ch.ready;

  always_comb begin
    ticks_nxt = ticks_r;
    state_nxt = state_r;
    res_valid = 1'b0;
    res_word  = merge_word;
    case (in_ch.kind)
      KIND_PACKET: begin
        state_nxt = merge_state;
        ticks_nxt = '0;
        res_valid = 1'b1;
      end
      KIND_TICK: begin
        if (ticks_r != TICKS_MAX) begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
      KIND_RX_FAIL: begin
        if (ticks_r >= timeout_r) begin
          ticks_nxt               = '0;
          res_valid               = 1'b1;
          res_word                = '0;
          res_word.whole_led_mode = MODE_LINK_FAIL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      ticks_r      <= '0;
      state_r      <= '{fired_marks: '0, fire_enabled: 1'b1, fire_held: 1'b0};
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (in_accept) begin
        ticks_r <= ticks_nxt;
        state_r <= state_nxt;
      end
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_accept & res_valid;
        end
      end else if (in_accept && res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_word_r <= skid_word_r;
      end else begin
        out_word_r <= res_word;
      end
    end else if (in_accept && res_valid) begin
      skid_word_r <= res_word;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.response_sent  = out_word_r.response_sent;
  assign out_ch.armed_report   = out_word_r.armed_report;
  assign out_ch.fired_report   = out_word_r.fired_report;
  assign out_ch.fire_command   = out_word_r.fire_command;
  assign out_ch.whole_led_mode = out_word_r.whole_led_mode;
  assign out_ch.led_code_0     = out_word_r.led_code[0];
  assign out_ch.led_code_1     = out_word_r.led_code[1];
  assign out_ch.led_code_2     = out_word_r.led_code[2];
  assign out_ch.led_code_3     = out_word_r.led_code[3];

endmodule

// File: rtl/lafi_checker.sv
// Port-level checker for the interlock and the bind that attaches it to the top level.
module lafi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       response_sent,
  input logic [3:0] armed_report,
  input logic [3:0] fired_report,
  input logic       fire_command,
  input logic [1:0] whole_led_mode
);
  import lafi_pkg::*;

  // A stalled reply word must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("reply word dropped while stalled");

  // A charge is never reported both armed and already fired.
  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (armed_report & fired_report) == 4'd0)
    else $error("charge reported armed and fired at once");

  // A fire command needs a reply packet with at least one armed charge.
  a_fire_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fire_command |-> response_sent && armed_report != 4'd0)
    else $error("fire command without an armed charge");

  // A word that is not a reply packet is the bare link failure indication.
  a_link_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !response_sent |->
      whole_led_mode == MODE_LINK_FAIL && armed_report == 4'd0 && !fire_command)
    else $error("malformed link failure word");

endmodule

bind launch_arm_fire_interlock_top lafi_checker u_lafi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .response_sent  (out_ch.response_sent),
  .armed_report   (out_ch.armed_report),
  .fired_report   (out_ch.fired_report),
  .fire_command   (out_ch.fire_command),
  .whole_led_mode (out_ch.whole_led_mode)
);
